/* hw/rtl/utfd_pkg.sv */
// Shared widths, types and the lead byte classifier of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package utfd_pkg;

  localparam int CP_W    = 21;
  localparam int COUNT_W = 3;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CP_W-1:0]    last_cp;
    logic               last_err;
  } burst_t;

  typedef struct packed {
    logic            emit;
    logic            err;
    logic [CP_W-1:0] cp;
    logic [1:0]      expected;
    logic [CP_W-1:0] partial;
  } lead_t;

  function automatic lead_t take_lead(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (b[7] == 1'b0) begin
      r.emit = 1'b1;
      r.cp   = {{(CP_W-8){1'b0}}, b};
    end else if (b[7:5] == 3'b110) begin
      r.expected = 2'd1;
      r.partial  = {{(CP_W-5){1'b0}}, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      r.expected = 2'd2;
      r.partial  = {{(CP_W-4){1'b0}}, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      r.expected = 2'd3;
      r.partial  = {{(CP_W-3){1'b0}}, b[2:0]};
    end else begin
      r.emit = 1'b1;
      r.err  = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/utfd_byte_if.sv */
// Handshake channel that carries one byte item of the text stream.
`timescale 1ns / 1ps
`default_nettype none
interface utfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       flush;

  modport source (output valid, output data_byte, output flush, input ready);
  modport sink (input valid, input data_byte, input flush, output ready);
endinterface
`default_nettype wire

/* hw/rtl/utfd_char_if.sv */
// Handshake channel that carries one decoded character or error item.
`timescale 1ns / 1ps
`default_nettype none
interface utfd_char_if;
  logic                      valid;
  logic                      ready;
  logic [utfd_pkg::CP_W-1:0] code_point;
  logic                      is_error;
  logic                      last_of_run;

  modport source (output valid, output code_point, output is_error, output last_of_run,
                  input ready);
  modport sink (input valid, input code_point, input is_error, input last_of_run,
                output ready);
endinterface
`default_nettype wire

/* hw/rtl/utfd_decode.sv */
// Sequence state and the decode logic that turns one byte item into a result burst.
`timescale 1ns / 1ps
`default_nettype none
module utfd_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       item_byte,
  input  wire logic             item_flush,
  input  wire logic             take,
  output utfd_pkg::burst_t      burst
);
  import utfd_pkg::*;

  logic [1:0]      bytes_expected, bytes_expected_next;
  logic [1:0]      bytes_taken, bytes_taken_next;
  logic [CP_W-1:0] partial_code, partial_code_next;

  lead_t              lead;
  logic [COUNT_W-1:0] errs;
  logic [1:0]         taken_inc;
  logic [CP_W-1:0]    new_partial;
  logic               is_cont;

  always_comb begin
    lead        = take_lead(item_byte);
    errs        = {1'b0, bytes_taken} + 3'd1;
    taken_inc   = bytes_taken + 2'd1;
    new_partial = {partial_code[CP_W-7:0], item_byte[5:0]};
    is_cont     = (item_byte[7:6] == 2'b10);

    burst               = '0;
    bytes_expected_next = bytes_expected;
    bytes_taken_next    = bytes_taken;
    partial_code_next   = partial_code;

    if (item_flush) begin
      if (bytes_expected != 2'd0) begin
        burst.count         = errs;
        burst.last_err      = 1'b1;
        bytes_expected_next = 2'd0;
        bytes_taken_next    = 2'd0;
        partial_code_next   = '0;
      end
    end else if (bytes_expected == 2'd0) begin
      burst.count         = {2'b00, lead.emit};
      burst.last_cp       = lead.cp;
      burst.last_err      = lead.err;
      bytes_expected_next = lead.expected;
      bytes_taken_next    = 2'd0;
      partial_code_next   = lead.partial;
    end else if (is_cont) begin
      partial_code_next = new_partial;
      bytes_taken_next  = taken_inc;
      if (taken_inc >= bytes_expected) begin
        burst.count         = 3'd1;
        burst.last_cp       = new_partial;
        burst.last_err      = 1'b0;
        bytes_expected_next = 2'd0;
        bytes_taken_next    = 2'd0;
        partial_code_next   = '0;
      end
    end else begin
      // The pending bytes become errors and the breaking byte starts over as a lead.
      burst.count         = errs + {2'b00, lead.emit};
      burst.last_cp       = lead.emit ? lead.cp : '0;
      burst.last_err      = lead.emit ? lead.err : 1'b1;
      bytes_expected_next = lead.expected;
      bytes_taken_next    = 2'd0;
      partial_code_next   = lead.partial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected <= 2'd0;
      bytes_taken    <= 2'd0;
      partial_code   <= '0;
    end else if (take) begin
      bytes_expected <= bytes_expected_next;
      bytes_taken    <= bytes_taken_next;
      partial_code   <= partial_code_next;
    end
  end

`ifndef SYNTHESIS
  a_taken_below_expected: assert property (@(posedge clk) disable iff (rst)
    (bytes_expected != 2'd0) |-> (bytes_taken < bytes_expected))
    else $error("continuation count reached the expected length without completing");

  a_idle_is_clear: assert property (@(posedge clk) disable iff (rst)
    (bytes_expected == 2'd0) |-> (bytes_taken == 2'd0 && partial_code == '0))
    else $error("idle decoder holds stale sequence state");

  a_burst_bounded: assert property (@(posedge clk) disable iff (rst)
    take |-> (burst.count <= 3'd4))
    else $error("one byte item produced more than four results");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utfd_burst.sv */
// Result register that hands out a burst of results one item per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none
module utfd_burst (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,
  input  wire utfd_pkg::burst_t burst,
  output logic              can_load,
  utfd_char_if.source       char_out
);
  import utfd_pkg::*;

  logic [COUNT_W-1:0] remain;
  logic [CP_W-1:0]    last_cp;
  logic               last_err;
  logic               fire;
  logic               is_last;

  assign is_last              = (remain == 3'd1);
  assign fire                 = char_out.valid && char_out.ready;
  assign can_load             = (remain == 3'd0) || (is_last && char_out.ready);
  assign char_out.valid       = (remain != 3'd0);
  assign char_out.code_point  = is_last ? last_cp : '0;
  assign char_out.is_error    = is_last ? last_err : 1'b1;
  assign char_out.last_of_run = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (take && burst.count != 3'd0) begin
      remain <= burst.count;
    end else if (fire) begin
      remain <= remain - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && burst.count != 3'd0) begin
      last_cp  <= burst.last_cp;
      last_err <= burst.last_err;
    end
  end

`ifndef SYNTHESIS
  a_remain_bounded: assert property (@(posedge clk) disable iff (rst)
    remain <= 3'd4)
    else $error("result burst longer than four items");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (take && burst.count != 3'd0) |-> (remain == 3'd0 || (is_last && fire)))
    else $error("burst loaded over results not yet delivered");

  a_early_items_are_errors: assert property (@(posedge clk) disable iff (rst)
    (char_out.valid && !char_out.last_of_run) |->
      (char_out.is_error && char_out.code_point == '0))
    else $error("non-final item of a burst is not a plain error");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utf8_stream_decoder_core.sv */
// Top level of the UTF-8 stream decoder: input register, decode stage and result register.
// A byte item is held in the input register and its results, if any, are loaded into the result
// register, which waits while results of an earlier burst are still pending.
// Throughput: one byte item per cycle while each item gives at most one result and the receiver is ready.
// An item that gives n results (up to four) holds the input until its last result is taken.
// Reset is synchronous: it clears the sequence state and drops all pending items.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_core (
  input  wire logic   clk,
  input  wire logic   rst,
  utfd_byte_if.sink   byte_in,
  utfd_char_if.source char_out
);
  import utfd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_flush;
  logic       s1_take;
  logic       can_load;
  burst_t     burst;

  assign s1_take       = s1_valid && can_load;
  assign byte_in.ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_byte  <= byte_in.data_byte;
      s1_flush <= byte_in.flush;
    end
  end

  utfd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_byte  (s1_byte),
    .item_flush (s1_flush),
    .take       (s1_take),
    .burst      (burst)
  );

  utfd_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .take     (s1_take),
    .burst    (burst),
    .can_load (can_load),
    .char_out (char_out)
  );

endmodule
`default_nettype wire
